>>> rtl/core/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Field widths, request codes, status codes, sequencer states and the
// control word of the entry memory.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int FUNC_W   = 4;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 4'd0,
    FN_GET     = 4'd1,
    FN_APPEND  = 4'd2,
    FN_SET     = 4'd3,
    FN_SEARCH  = 4'd4,
    FN_INSERT  = 4'd5,
    FN_REMOVE  = 4'd6,
    FN_DEQUEUE = 4'd7,
    FN_POP     = 4'd8,
    FN_PEEK    = 4'd9
  } ile_func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } ile_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DEQ,
    S_SHUP,
    S_INSW,
    S_SHDN,
    S_SCAN,
    S_DONE
  } ile_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ile_mem_ctl_t;

endpackage

>>> rtl/core/ile_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ifs: request and response channels of the indexed list engine
// Each channel carries valid, ready and one word of payload.
// ----------------------------------------------------------------------------
interface ile_req_if;
  import ile_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [POS_W-1:0]   position_in;
  logic [VALUE_W-1:0] value_in;

  modport source (output valid, func, position_in, value_in, input ready);
  modport sink (input valid, func, position_in, value_in, output ready);
endinterface

interface ile_rsp_if;
  import ile_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic [FOUND_W-1:0]  position_out;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, status, value_out, position_out, count, input ready);
  modport sink (input valid, status, value_out, position_out, count, output ready);
endinterface

>>> rtl/core/ile_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_mem: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  ile_pkg::ile_mem_ctl_t    ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data_r
);
  import ile_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/ile_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_seq: request sequencer of the indexed list engine
// Decodes a request, walks the entry memory for shifts and searches, keeps
// the entry count and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ile_seq #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ile_req_if.sink                     in_ch,
  ile_rsp_if.source                   out_ch,
  output ile_pkg::ile_mem_ctl_t       mem_ctl,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [WORD_BITS-1:0]        wr_data,
  input  logic [WORD_BITS-1:0]        rd_data
);
  import ile_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  ile_state_t          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [WORD_BITS-1:0] rd_r, rd_nxt;
  logic [AW-1:0]       found_r, found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [FOUND_W-1:0]  out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [LW-1:0] pos_x, cnt_x;
  logic [AW-1:0] pos_a, cnt_a, last_a;
  logic          pos_lt, pos_eq, pos_gt, pos_last, full, empty;
  logic          ptr_at_pos, ptr_at_last, hit, out_free;

  assign pos_x       = LW'(pos_r);
  assign cnt_x       = LW'(count_r);
  assign pos_a       = AW'(pos_r);
  assign cnt_a       = AW'(count_r);
  assign last_a      = AW'(count_r - CW'(1));
  assign pos_lt      = pos_x < cnt_x;
  assign pos_eq      = pos_x == cnt_x;
  assign pos_gt      = pos_x > cnt_x;
  assign pos_last    = pos_x == (cnt_x - LW'(1));
  assign full        = count_r == CW'(CAPACITY);
  assign empty       = count_r == '0;
  assign ptr_at_pos  = ptr_r == pos_a;
  assign ptr_at_last = ptr_r == last_a;
  assign hit         = rd_data == val_r;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (func_r)
          FN_GET:     state_nxt = pos_lt ? S_READ : S_DONE;
          FN_SEARCH:  state_nxt = empty ? S_DONE : S_SCAN;
          FN_INSERT:  state_nxt = (pos_gt || full || pos_eq) ? S_DONE : S_SHUP;
          FN_REMOVE:  state_nxt = (!pos_lt || pos_last) ? S_DONE : S_SHDN;
          FN_DEQUEUE: state_nxt = empty ? S_DONE : S_DEQ;
          FN_POP:     state_nxt = empty ? S_DONE : S_READ;
          FN_PEEK:    state_nxt = empty ? S_DONE : S_READ;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_READ:  state_nxt = S_DONE;
      S_DEQ:   state_nxt = S_EXEC;
      S_SHUP:  state_nxt = ptr_at_pos ? S_INSW : S_SHUP;
      S_INSW:  state_nxt = S_DONE;
      S_SHDN:  state_nxt = ptr_at_last ? S_DONE : S_SHDN;
      S_SCAN:  state_nxt = (hit || ptr_at_last) ? S_DONE : S_SCAN;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    func_nxt       = func_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    mem_ctl        = '0;
    rd_addr        = ptr_r;
    wr_addr        = ptr_r;
    wr_data        = val_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt   = in_ch.func;
          pos_nxt    = in_ch.position_in;
          val_nxt    = WORD_BITS'(in_ch.value_in);
          status_nxt = ST_OK;
          rd_nxt     = '0;
          found_nxt  = '0;
        end
      end
      S_EXEC: begin
        unique case (func_r)
          FN_CLEAR: count_nxt = '0;
          FN_GET: begin
            if (pos_lt) begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = pos_a;
            end else begin
              status_nxt = ST_MISS;
            end
          end
          FN_APPEND: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_ctl.wr_en = 1'b1;
              wr_addr       = cnt_a;
              count_nxt     = count_r + CW'(1);
            end
          end
          FN_SET: begin
            if (pos_lt) begin
              mem_ctl.wr_en = 1'b1;
              wr_addr       = pos_a;
            end else if (!pos_eq) begin
              status_nxt = ST_MISS;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_ctl.wr_en = 1'b1;
              wr_addr       = cnt_a;
              count_nxt     = count_r + CW'(1);
            end
          end
          FN_SEARCH: begin
            if (empty) begin
              status_nxt = ST_MISS;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = '0;
              ptr_nxt       = '0;
            end
          end
          FN_INSERT: begin
            if (pos_gt) begin
              status_nxt = ST_MISS;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else if (pos_eq) begin
              mem_ctl.wr_en = 1'b1;
              wr_addr       = cnt_a;
              count_nxt     = count_r + CW'(1);
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = last_a;
              ptr_nxt       = last_a;
            end
          end
          FN_REMOVE: begin
            if (!pos_lt) begin
              status_nxt = ST_MISS;
            end else if (pos_last) begin
              count_nxt = count_r - CW'(1);
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = pos_a + AW'(1);
              ptr_nxt       = pos_a + AW'(1);
            end
          end
          FN_DEQUEUE: begin
            if (empty) begin
              status_nxt = ST_MISS;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = '0;
            end
          end
          FN_POP: begin
            if (empty) begin
              status_nxt = ST_MISS;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = last_a;
              count_nxt     = count_r - CW'(1);
            end
          end
          FN_PEEK: begin
            if (empty) begin
              status_nxt = ST_MISS;
            end else begin
              mem_ctl.rd_en = 1'b1;
              rd_addr       = last_a;
            end
          end
          default: status_nxt = ST_MISS;
        endcase
      end
      S_READ: rd_nxt = rd_data;
      S_DEQ: begin
        // The front word is kept; the rest of the request runs as a remove at zero.
        rd_nxt   = rd_data;
        func_nxt = FN_REMOVE;
        pos_nxt  = '0;
      end
      S_SHUP: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = ptr_r + AW'(1);
        wr_data       = rd_data;
        if (!ptr_at_pos) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = ptr_r - AW'(1);
          ptr_nxt       = ptr_r - AW'(1);
        end
      end
      S_INSW: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = pos_a;
        count_nxt     = count_r + CW'(1);
      end
      S_SHDN: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = ptr_r - AW'(1);
        wr_data       = rd_data;
        if (ptr_at_last) begin
          count_nxt = count_r - CW'(1);
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = ptr_r + AW'(1);
          ptr_nxt       = ptr_r + AW'(1);
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt = ptr_r;
        end else if (ptr_at_last) begin
          status_nxt = ST_MISS;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = ptr_r + AW'(1);
          ptr_nxt       = ptr_r + AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = VALUE_W'(rd_r);
          out_found_nxt  = FOUND_W'(found_r);
          out_count_nxt  = COUNT_W'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.value_out    = out_value_r;
  assign out_ch.position_out = out_found_r;
  assign out_ch.count        = out_count_r;

endmodule

>>> rtl/core/indexed_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine: bounded ordered list of words
// Requests arrive as words on in_ch (func, position_in, value_in); each
// request returns exactly one result word on out_ch (status, value_out,
// position_out, count). Both channels move a word at a rising edge of clk.
// Requests are served one at a time. Clear, append and set write at most
// one entry, and get, pop and peek read at most one. Search reads one entry
// after another until a hit or the last entry; insert and remove shift the
// later entries one by one, and dequeue reads the front entry and then
// runs as a remove at position zero. The single memory read port sets
// the walk at one entry per cycle. The engine is ready for a new request
// once the previous result is loaded into the output register.
// A result that out_ch does not take stays in the output register; the next
// request is still accepted and runs, and its result waits until the
// register is free. Reset empties the list and drops any pending result;
// the memory is not cleared.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_req_if.sink   in_ch,
  ile_rsp_if.source out_ch
);
  import ile_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  ile_mem_ctl_t         mem_ctl;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_data;

  ile_seq #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  ile_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_r (rd_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a request is in progress");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.rd_en && mem_ctl.wr_en |-> rd_addr != wr_addr)
    else $error("entry memory read and written at the same address");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> !in_ch.ready)
    else $error("entry memory written while idle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_MISS ||
                      out_ch.status == ST_FULL))
    else $error("result word carries an undefined status");

endmodule
